### hw/rtl/tbb_pkg.sv
`default_nettype none

package tbb_pkg;

    // image geometry
    localparam int unsigned MAX_DIM = 4096;
    localparam int unsigned DIM_W   = $clog2(MAX_DIM);
    localparam int unsigned LEN_W   = DIM_W + 1;

    // trim colour slots
    localparam int unsigned TRIM_SLOTS = 4;

    // classified item queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // configuration port
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_LEVEL   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVEL  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_ENABLE  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_COLOR_0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_COLOR_1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_COLOR_2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_COLOR_3 = 4'd7;

    // reset value of the gray level: nothing is background by gray
    localparam logic [8:0] GRAY_RESET = 9'd256;

    // settings the classifier needs
    typedef struct packed {
        logic [8:0]                       gray_level;
        logic [7:0]                       alpha_level;
        logic [TRIM_SLOTS-1:0]            trim_enable;
        logic [TRIM_SLOTS-1:0][31:0]      trim_color;
    } tbb_cls_cfg_t;

    // one classified pixel
    typedef struct packed {
        logic background;
        logic row_end;
        logic frame_end;
    } tbb_item_t;

    // bounding box at frame end, before margin
    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] bottom;
        logic [LEN_W-1:0] width;
        logic [LEN_W-1:0] height;
    } tbb_box_t;

    // box after margin and clamp
    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] bottom;
    } tbb_clamp_t;

endpackage

`default_nettype wire

### hw/rtl/tbb_front.sv
`default_nettype none

module tbb_front (
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // pixel_color
    input  wire logic                  s_tlast,   // row_end
    input  wire logic                  s_tuser,   // frame_end
    input  wire tbb_pkg::tbb_cls_cfg_t cfg,
    input  wire logic                  q_full,
    output logic                       q_push,
    output tbb_pkg::tbb_item_t         q_item
);

    logic [7:0]  alpha;
    logic [9:0]  gray_sum;
    logic [10:0] gray_limit;
    logic        by_gray;
    logic        by_alpha;
    logic        by_trim;

    // channel split
    assign alpha    = s_tdata[31:24];
    assign gray_sum = {2'b00, s_tdata[23:16]} + {2'b00, s_tdata[15:8]}
                    + {2'b00, s_tdata[7:0]};

    // average at or above threshold is the same as sum at or above three times it
    assign gray_limit = {1'b0, cfg.gray_level, 1'b0} + {2'b00, cfg.gray_level};
    assign by_gray    = ({1'b0, gray_sum} >= gray_limit);
    assign by_alpha   = (alpha <= cfg.alpha_level);

    // enabled trim colour match
    always_comb begin
        by_trim = 1'b0;
        for (int k = 0; k < tbb_pkg::TRIM_SLOTS; k++) begin
            if (cfg.trim_enable[k] && (cfg.trim_color[k] == s_tdata)) begin
                by_trim = 1'b1;
            end
        end
    end

    // accept while the queue has room
    assign s_tready          = !q_full;
    assign q_push            = s_tvalid && !q_full;
    assign q_item.background = by_gray || by_alpha || by_trim;
    assign q_item.row_end    = s_tlast;
    assign q_item.frame_end  = s_tuser;

endmodule

`default_nettype wire

### hw/rtl/tbb_queue.sv
`default_nettype none

module tbb_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire tbb_pkg::tbb_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output tbb_pkg::tbb_item_t      head_item
);

    tbb_pkg::tbb_item_t           entry_reg [tbb_pkg::Q_DEPTH];
    logic [tbb_pkg::Q_AW-1:0]     wr_ptr_reg;
    logic [tbb_pkg::Q_AW-1:0]     wr_ptr_next;
    logic [tbb_pkg::Q_AW-1:0]     rd_ptr_reg;
    logic [tbb_pkg::Q_AW-1:0]     rd_ptr_next;
    logic [tbb_pkg::Q_AW:0]       count_reg;
    logic [tbb_pkg::Q_AW:0]       count_next;

    assign full       = (count_reg == (tbb_pkg::Q_AW+1)'(tbb_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tbb_track.sv
`default_nettype none

module tbb_track (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               head_valid,
    input  wire tbb_pkg::tbb_item_t head_item,
    output logic                    pop,
    input  wire logic               advance,
    output logic                    box_valid,
    output tbb_pkg::tbb_box_t       box
);

    localparam logic [tbb_pkg::DIM_W-1:0] DIM_TOP = tbb_pkg::DIM_W'(tbb_pkg::MAX_DIM - 1);

    logic [tbb_pkg::DIM_W-1:0] col_cnt_reg,  col_cnt_next;
    logic [tbb_pkg::DIM_W-1:0] row_cnt_reg,  row_cnt_next;
    logic                      found_reg,    found_next;
    logic [tbb_pkg::DIM_W-1:0] min_col_reg,  min_col_next;
    logic [tbb_pkg::DIM_W-1:0] max_col_reg,  max_col_next;
    logic [tbb_pkg::DIM_W-1:0] min_row_reg,  min_row_next;
    logic [tbb_pkg::DIM_W-1:0] max_row_reg,  max_row_next;
    logic                      box_valid_reg, box_valid_next;
    tbb_pkg::tbb_box_t         box_reg,      box_next;
    logic                      fg;
    logic [tbb_pkg::DIM_W-1:0] min_col_upd, max_col_upd, min_row_upd, max_row_upd;

    assign pop       = head_valid && advance;
    assign fg        = !head_item.background;
    assign box_valid = box_valid_reg;
    assign box       = box_reg;

    // extremes including the pixel at the head
    always_comb begin
        min_col_upd = min_col_reg;
        max_col_upd = max_col_reg;
        min_row_upd = min_row_reg;
        max_row_upd = max_row_reg;
        if (fg) begin
            if (!found_reg || col_cnt_reg < min_col_reg) min_col_upd = col_cnt_reg;
            if (!found_reg || col_cnt_reg > max_col_reg) max_col_upd = col_cnt_reg;
            if (!found_reg || row_cnt_reg < min_row_reg) min_row_upd = row_cnt_reg;
            if (!found_reg || row_cnt_reg > max_row_reg) max_row_upd = row_cnt_reg;
        end
    end

    // frame state update and box capture
    always_comb begin
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        found_next     = found_reg;
        min_col_next   = min_col_reg;
        max_col_next   = max_col_reg;
        min_row_next   = min_row_reg;
        max_row_next   = max_row_reg;
        box_valid_next = box_valid_reg;
        box_next       = box_reg;
        if (advance) begin
            box_valid_next = pop && head_item.frame_end;
        end
        if (pop) begin
            if (head_item.frame_end) begin
                // box of this frame, then clear for the next one
                box_next.width  = {1'b0, col_cnt_reg} + 1'b1;
                box_next.height = {1'b0, row_cnt_reg} + 1'b1;
                if (found_reg || fg) begin
                    box_next.left   = min_col_upd;
                    box_next.right  = max_col_upd;
                    box_next.top    = min_row_upd;
                    box_next.bottom = max_row_upd;
                end else begin
                    box_next.left   = col_cnt_reg;
                    box_next.right  = '0;
                    box_next.top    = row_cnt_reg;
                    box_next.bottom = '0;
                end
                col_cnt_next = '0;
                row_cnt_next = '0;
                found_next   = 1'b0;
                min_col_next = '1;
                max_col_next = '0;
                min_row_next = '1;
                max_row_next = '0;
            end else begin
                found_next   = found_reg || fg;
                min_col_next = min_col_upd;
                max_col_next = max_col_upd;
                min_row_next = min_row_upd;
                max_row_next = max_row_upd;
                if (head_item.row_end) begin
                    col_cnt_next = '0;
                    if (row_cnt_reg < DIM_TOP) row_cnt_next = row_cnt_reg + 1'b1;
                end else if (col_cnt_reg < DIM_TOP) begin
                    col_cnt_next = col_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            found_reg     <= 1'b0;
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            min_row_reg   <= '1;
            max_row_reg   <= '0;
            box_valid_reg <= 1'b0;
        end else begin
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            found_reg     <= found_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            box_valid_reg <= box_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        box_reg <= box_next;
    end

endmodule

`default_nettype wire

### hw/rtl/tbb_crop.sv
`default_nettype none

module tbb_crop (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [tbb_pkg::DIM_W-1:0]   margin,
    input  wire logic                        box_valid,
    input  wire tbb_pkg::tbb_box_t           box,
    output logic                             advance,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [47:0]                      m_tdata,   // crop_left, crop_top, crop_width, crop_height
    output logic                             m_tuser    // crop_valid
);

    localparam int unsigned W = tbb_pkg::DIM_W;

    logic                  clamp_valid_reg, clamp_valid_next;
    tbb_pkg::tbb_clamp_t   clamp_reg, clamp_next;
    logic                  out_valid_reg, out_valid_next;
    logic [47:0]           out_data_reg, out_data_next;
    logic                  out_flag_reg, out_flag_next;
    logic [W:0]            right_wide, bottom_wide;
    logic [W:0]            width_wide, height_wide;
    logic                  width_pos, height_pos;

    // pipeline moves when the output register is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

    // margin and clamp to the image
    assign right_wide  = {1'b0, box.right}  + {1'b0, margin};
    assign bottom_wide = {1'b0, box.bottom} + {1'b0, margin};

    always_comb begin
        clamp_next.left   = (box.left < margin) ? '0 : box.left - margin;
        clamp_next.top    = (box.top  < margin) ? '0 : box.top  - margin;
        clamp_next.right  = (right_wide  >= box.width)  ? W'(box.width  - 1'b1)
                                                        : right_wide[W-1:0];
        clamp_next.bottom = (bottom_wide >= box.height) ? W'(box.height - 1'b1)
                                                        : bottom_wide[W-1:0];
    end

    // crop size, zero when not positive
    assign width_pos   = clamp_reg.right  > clamp_reg.left;
    assign height_pos  = clamp_reg.bottom > clamp_reg.top;
    assign width_wide  = {1'b0, clamp_reg.right}  - {1'b0, clamp_reg.left};
    assign height_wide = {1'b0, clamp_reg.bottom} - {1'b0, clamp_reg.top};

    always_comb begin
        clamp_valid_next = clamp_valid_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_flag_next    = out_flag_reg;
        if (advance) begin
            clamp_valid_next = box_valid;
            out_valid_next   = clamp_valid_reg;
            out_data_next    = {height_pos ? height_wide[W-1:0] : W'(0),
                                width_pos  ? width_wide[W-1:0]  : W'(0),
                                clamp_reg.top, clamp_reg.left};
            out_flag_next    = width_pos && height_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            clamp_valid_reg <= clamp_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            clamp_reg <= clamp_next;
        end
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

endmodule

`default_nettype wire

### hw/rtl/trim_border_bounding_box.sv
`default_nettype none

// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tdata pixel_color, tlast row_end, tuser frame_end
// m_        out  m_tvalid/m_tready    tdata left/top/width/height, tuser crop_valid
// cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// one pixel per clock while the queue has room; the classifier feeds a four-entry queue
// m_tvalid rises once the frame-end pixel has passed through the registered stages
// (queue, box capture, margin clamp, output register)
// aresetn is synchronous; a stalled m_ side holds the back end while the queue absorbs pixels
// cfg_ready is always high; write only while no frame is in flight

module trim_border_bounding_box (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // pixel_color
    input  wire logic                          s_tlast,   // row_end
    input  wire logic                          s_tuser,   // frame_end
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // crop_left, crop_top, crop_width, crop_height
    output logic [47:0]                        m_tdata,
    output logic                               m_tuser,   // crop_valid
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    logic [8:0]                            gray_reg;
    logic [7:0]                            alpha_reg;
    logic [tbb_pkg::DIM_W-1:0]             margin_reg;
    logic [tbb_pkg::TRIM_SLOTS-1:0]        trim_en_reg;
    logic [tbb_pkg::TRIM_SLOTS-1:0][31:0]  trim_color_reg;
    tbb_pkg::tbb_cls_cfg_t                 cls_cfg;
    logic                                  q_full, q_push, q_pop, head_valid;
    tbb_pkg::tbb_item_t                    push_item, head_item;
    logic                                  advance, box_valid;
    tbb_pkg::tbb_box_t                     box;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_reg       <= tbb_pkg::GRAY_RESET;
            alpha_reg      <= '0;
            margin_reg     <= '0;
            trim_en_reg    <= '0;
            trim_color_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tbb_pkg::CFG_GRAY_LEVEL:   gray_reg    <= cfg_data[8:0];
                tbb_pkg::CFG_ALPHA_LEVEL:  alpha_reg   <= cfg_data[7:0];
                tbb_pkg::CFG_MARGIN:       margin_reg  <= cfg_data[tbb_pkg::DIM_W-1:0];
                tbb_pkg::CFG_TRIM_ENABLE:  trim_en_reg <= cfg_data[tbb_pkg::TRIM_SLOTS-1:0];
                tbb_pkg::CFG_TRIM_COLOR_0: trim_color_reg[0] <= cfg_data;
                tbb_pkg::CFG_TRIM_COLOR_1: trim_color_reg[1] <= cfg_data;
                tbb_pkg::CFG_TRIM_COLOR_2: trim_color_reg[2] <= cfg_data;
                tbb_pkg::CFG_TRIM_COLOR_3: trim_color_reg[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cls_cfg.gray_level  = gray_reg;
    assign cls_cfg.alpha_level = alpha_reg;
    assign cls_cfg.trim_enable = trim_en_reg;
    assign cls_cfg.trim_color  = trim_color_reg;

    // classifier
    tbb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .cfg      (cls_cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // queue between classifier and tracker
    tbb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // row, column and extremes
    tbb_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .advance    (advance),
        .box_valid  (box_valid),
        .box        (box)
    );

    // margin, clamp and result register
    tbb_crop u_crop (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .margin    (margin_reg),
        .box_valid (box_valid),
        .box       (box),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

### bench/trim_border_bounding_box_checker.sv
`timescale 1ns / 100ps

// watches the pixel, crop and register channels of the autocrop block,
// predicts every crop and compares it with what comes out
module trim_border_bounding_box_checker
    import tbb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [31:0]          s_tdata,   // pixel_color
    input  wire logic                 s_tlast,   // row_end
    input  wire logic                 s_tuser,   // frame_end
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [47:0]          m_tdata,   // crop_left, crop_top, crop_width, crop_height
    input  wire logic                 m_tuser,   // crop_valid
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output int                        mismatch_count,
    output int                        crop_pending,
    output int                        crop_checked
);

    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             valid;
    } crop_t;

    // shadow of the register file
    logic [8:0]                 gray_level;
    logic [7:0]                 alpha_level;
    logic [DIM_W-1:0]           margin_px;
    logic [TRIM_SLOTS-1:0]      trim_mask;
    logic [31:0]                trim_rgb [TRIM_SLOTS];

    // running scan of the current frame
    logic [DIM_W-1:0]           col_pos;
    logic [DIM_W-1:0]           row_pos;
    logic [LEN_W-1:0]           row_len;
    logic                       seen_fg;
    logic [DIM_W-1:0]           fg_left;
    logic [DIM_W-1:0]           fg_right;
    logic [DIM_W-1:0]           fg_top;
    logic [DIM_W-1:0]           fg_bottom;

    crop_t                      crop_expected [$];
    int                         errors;
    int                         checked;

    // background by gray level, by transparency or by an enabled trim colour
    function automatic logic pixel_is_background(input logic [31:0] px);
        logic [9:0] sum;
        logic [9:0] avg;
        logic       hit;
        sum = {2'b00, px[23:16]} + {2'b00, px[15:8]} + {2'b00, px[7:0]};
        avg = sum / 10'd3;
        hit = (avg >= {1'b0, gray_level}) || (px[31:24] <= alpha_level);
        for (int k = 0; k < TRIM_SLOTS; k++) begin
            if (trim_mask[k] && trim_rgb[k] == px)
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic clear_scan();
        col_pos   = '0;
        row_pos   = '0;
        seen_fg   = 1'b0;
        fg_left   = '1;
        fg_right  = '0;
        fg_top    = '1;
        fg_bottom = '0;
    endtask

    // one accepted pixel: update the box, and at frame end queue the crop
    task automatic bbox_take_pixel(input logic [31:0] px, input logic rend, input logic fend);
        int    w;
        int    h;
        int    lft;
        int    rgt;
        int    tp;
        int    bot;
        int    cw;
        int    ch;
        crop_t want;
        if (!pixel_is_background(px)) begin
            if (!seen_fg || col_pos < fg_left)   fg_left   = col_pos;
            if (!seen_fg || col_pos > fg_right)  fg_right  = col_pos;
            if (!seen_fg || row_pos < fg_top)    fg_top    = row_pos;
            if (!seen_fg || row_pos > fg_bottom) fg_bottom = row_pos;
            seen_fg = 1'b1;
        end
        if (!fend) begin
            if (rend) begin
                row_len = {1'b0, col_pos} + 1'b1;
                col_pos = '0;
                if (int'(row_pos) < MAX_DIM - 1)
                    row_pos = row_pos + 1'b1;
            end else if (int'(col_pos) < MAX_DIM - 1) begin
                col_pos = col_pos + 1'b1;
            end
        end else begin
            row_len = {1'b0, col_pos} + 1'b1;
            w = int'(row_len);
            h = int'(row_pos) + 1;
            if (seen_fg) begin
                lft = int'(fg_left);
                rgt = int'(fg_right);
                tp  = int'(fg_top);
                bot = int'(fg_bottom);
            end else begin
                lft = w - 1;
                rgt = 0;
                tp  = h - 1;
                bot = 0;
            end
            // widen by the margin, then clamp to the image
            lft = lft - int'(margin_px);
            tp  = tp - int'(margin_px);
            rgt = rgt + int'(margin_px);
            bot = bot + int'(margin_px);
            if (lft < 0)  lft = 0;
            if (tp < 0)   tp = 0;
            if (rgt >= w) rgt = w - 1;
            if (bot >= h) bot = h - 1;
            cw = rgt - lft;
            ch = bot - tp;
            want.left   = lft[DIM_W-1:0];
            want.top    = tp[DIM_W-1:0];
            want.width  = (cw > 0) ? cw[DIM_W-1:0] : '0;
            want.height = (ch > 0) ? ch[DIM_W-1:0] : '0;
            want.valid  = (cw > 0) && (ch > 0);
            crop_expected.push_back(want);
            clear_scan();
        end
    endtask

    always @(posedge aclk) begin : watch
        crop_t got;
        crop_t want;
        if (!aresetn) begin
            gray_level  = GRAY_RESET;
            alpha_level = '0;
            margin_px   = '0;
            trim_mask   = '0;
            for (int k = 0; k < TRIM_SLOTS; k++)
                trim_rgb[k] = '0;
            row_len = '0;
            clear_scan();
            crop_expected.delete();
            errors  = 0;
            checked = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GRAY_LEVEL:   gray_level  = cfg_data[8:0];
                    CFG_ALPHA_LEVEL:  alpha_level = cfg_data[7:0];
                    CFG_MARGIN:       margin_px   = cfg_data[DIM_W-1:0];
                    CFG_TRIM_ENABLE:  trim_mask   = cfg_data[TRIM_SLOTS-1:0];
                    CFG_TRIM_COLOR_0: trim_rgb[0] = cfg_data;
                    CFG_TRIM_COLOR_1: trim_rgb[1] = cfg_data;
                    CFG_TRIM_COLOR_2: trim_rgb[2] = cfg_data;
                    CFG_TRIM_COLOR_3: trim_rgb[3] = cfg_data;
                    default: ;
                endcase
            end

            // crop results against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.left   = m_tdata[11:0];
                got.top    = m_tdata[23:12];
                got.width  = m_tdata[35:24];
                got.height = m_tdata[47:36];
                got.valid  = m_tuser;
                if (crop_expected.size() == 0) begin
                    if (errors < 10)
                        $display({"[%0t] unexpected crop: left %0d top %0d",
                                  " width %0d height %0d valid %0b"},
                                 $time, got.left, got.top, got.width, got.height,
                                 got.valid);
                    errors++;
                end else begin
                    want = crop_expected.pop_front();
                    checked++;
                    if (got.left !== want.left || got.top !== want.top ||
                        got.width !== want.width || got.height !== want.height ||
                        got.valid !== want.valid) begin
                        if (errors < 10) begin
                            $display("[%0t] crop mismatch", $time);
                            $display("    want left %0d top %0d width %0d height %0d valid %0b",
                                     want.left, want.top, want.width, want.height, want.valid);
                            $display("    got  left %0d top %0d width %0d height %0d valid %0b",
                                     got.left, got.top, got.width, got.height, got.valid);
                        end
                        errors++;
                    end
                end
            end

            // pixels taken by the block
            if (s_tvalid && s_tready)
                bbox_take_pixel(s_tdata, s_tlast, s_tuser);
        end
        mismatch_count <= errors;
        crop_pending   <= crop_expected.size();
        crop_checked   <= checked;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import tbb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int mismatch_count;
    int crop_pending;
    int crop_checked;

    int cycle_count   = 0;
    int ready_hold    = 0;
    bit calm          = 1'b0;
    int pixels_sent   = 0;
    int frames_sent   = 0;
    int settings_used = 0;

    // what the registers hold now, used to shape the pixels
    logic [8:0]  set_gray  = GRAY_RESET;
    logic [7:0]  set_alpha = '0;
    logic [31:0] set_color [TRIM_SLOTS];

    trim_border_bounding_box u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    trim_border_bounding_box_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .crop_pending   (crop_pending),
        .crop_checked   (crop_checked)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // crop receiver stalls in random bursts unless calm
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(4, 0) == 0) begin
            ready_hold <= $urandom_range(3, 0);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one pixel item, with an occasional gap in front of it
    task automatic send_pixel(input logic [31:0] px, input logic rend, input logic fend);
        int gap;
        if (!calm && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= rend;
        s_tuser  <= fend;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // stop pixels and wait until every crop is out and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (crop_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // all registers, unused upper data bits random, plus a write to a hole in the map
    task automatic apply_setting(input logic [8:0] gray, input logic [7:0] alpha,
                                 input logic [11:0] margin, input logic [3:0] trim,
                                 input logic [31:0] c0, input logic [31:0] c1,
                                 input logic [31:0] c2, input logic [31:0] c3);
        logic [CFG_IDX_W-1:0] hole;
        hole = CFG_TRIM_COLOR_3 + 1'b1 + CFG_IDX_W'($urandom_range(7, 0));
        write_reg(CFG_GRAY_LEVEL,   {23'($urandom()), gray});
        write_reg(CFG_ALPHA_LEVEL,  {24'($urandom()), alpha});
        write_reg(CFG_MARGIN,       {20'($urandom()), margin});
        write_reg(CFG_TRIM_ENABLE,  {28'($urandom()), trim});
        write_reg(CFG_TRIM_COLOR_0, c0);
        write_reg(CFG_TRIM_COLOR_1, c1);
        write_reg(CFG_TRIM_COLOR_2, c2);
        write_reg(CFG_TRIM_COLOR_3, c3);
        write_reg(hole,             $urandom());
        cfg_valid    <= 1'b0;
        set_gray     = gray;
        set_alpha    = alpha;
        set_color[0] = c0;
        set_color[1] = c1;
        set_color[2] = c2;
        set_color[3] = c3;
        settings_used++;
    endtask

    // opaque and dark enough to count as content
    function automatic logic [31:0] fg_pixel();
        int ch_max;
        int a_min;
        ch_max = (set_gray == 0) ? 0 : ((set_gray > 255) ? 255 : int'(set_gray) - 1);
        a_min  = (set_alpha == 8'hff) ? 255 : int'(set_alpha) + 1;
        return {8'($urandom_range(255, a_min)), 8'($urandom_range(ch_max, 0)),
                8'($urandom_range(ch_max, 0)), 8'($urandom_range(ch_max, 0))};
    endfunction

    // border: a trim colour, transparent, bright or plain noise
    function automatic logic [31:0] bg_pixel();
        int g;
        case ($urandom_range(3, 0))
            0: return set_color[$urandom_range(TRIM_SLOTS - 1, 0)];
            1: return {8'($urandom_range(int'(set_alpha), 0)), 24'($urandom())};
            2: begin
                if (set_gray > 255)
                    return $urandom();
                g = int'(set_gray);
                return {8'($urandom()), 8'($urandom_range(255, g)),
                        8'($urandom_range(255, g)), 8'($urandom_range(255, g))};
            end
            default: return $urandom();
        endcase
    endfunction

    // raster frame with content inside a random rectangle
    task automatic send_frame(input int width, input int height, input bit ragged,
                              input bit open_end, input bit blank);
        int          x0;
        int          x1;
        int          y0;
        int          y1;
        int          len;
        bit          last;
        bit          inside_box;
        logic [31:0] px;
        x0 = $urandom_range(width - 1, 0);
        x1 = $urandom_range(width - 1, x0);
        y0 = $urandom_range(height - 1, 0);
        y1 = $urandom_range(height - 1, y0);
        for (int r = 0; r < height; r++) begin
            len = ragged ? $urandom_range(width + 2, 1) : width;
            for (int c = 0; c < len; c++) begin
                last       = (r == height - 1) && (c == len - 1);
                inside_box = !blank && c >= x0 && c <= x1 && r >= y0 && r <= y1;
                if (inside_box && $urandom_range(2, 0) != 0)
                    px = fg_pixel();
                else
                    px = bg_pixel();
                if (!blank && $urandom_range(15, 0) == 0)
                    px = $urandom();
                send_pixel(px, last ? !open_end : (c == len - 1), last);
            end
        end
        frames_sent++;
    endtask

    initial begin : stimulus
        int          phase;
        int          nframes;
        logic [8:0]  g;
        logic [7:0]  a;
        logic [11:0] mg;
        logic [3:0]  te;
        logic [31:0] cl [4];

        for (int k = 0; k < TRIM_SLOTS; k++)
            set_color[k] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: only fully transparent pixels are border
        send_pixel(32'hff00_0000, 1'b1, 1'b1);      // single content pixel
        send_pixel(32'h00ff_ffff, 1'b1, 1'b1);      // single border pixel, no content
        for (int r = 0; r < 3; r++)                 // lone content pixel in the middle
            for (int c = 0; c < 3; c++)
                send_pixel((r == 1 && c == 1) ? 32'hff80_8080 : 32'h0000_0000,
                           c == 2, r == 2 && c == 2);
        for (int r = 0; r < 3; r++)                 // all white, frame end without row end
            for (int c = 0; c < 2; c++)
                send_pixel(32'hffff_ffff, c == 1 && r != 2, r == 2 && c == 1);
        send_pixel(32'h8012_3456, 1'b0, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(32'hffff_ffff, 1'b0, 1'b0);
        send_pixel(32'h7f80_8080, 1'b0, 1'b1);
        settle();

        phase = 0;
        while (pixels_sent < 420) begin
            for (int k = 0; k < 4; k++)
                cl[k] = {8'($urandom_range(255, 128)), 24'($urandom() & 32'h007f_7f7f)};
            g  = ($urandom_range(3, 0) == 0) ? 9'($urandom_range(256, 0))
                                             : 9'($urandom_range(240, 120));
            a  = ($urandom_range(3, 0) == 0) ? 8'($urandom()) : 8'($urandom_range(40, 0));
            case ($urandom_range(5, 0))
                0:       mg = '0;
                1:       mg = '1;
                2:       mg = 12'($urandom());
                default: mg = 12'($urandom_range(3, 1));
            endcase
            te = 4'($urandom());
            // the first phases pin the extremes
            case (phase)
                0: begin g = '0;         te = '0; end
                1: begin g = GRAY_RESET; a = 8'hff; mg = '1; te = '1; end
                2: begin
                    g = 9'd255; a = '0; mg = '0; te = '1;
                    cl[0] = '1; cl[1] = '0; cl[2] = $urandom();
                end
                3: begin g = 9'd128; a = 8'd128; mg = 12'd1; end
                5: begin g = 9'd200; a = 8'd10; mg = '0; end
                6: begin g = 9'd200; a = 8'd10; mg = '1; end
                default: ;
            endcase
            apply_setting(g, a, mg, te, cl[0], cl[1], cl[2], cl[3]);

            if (pixels_sent >= 360)
                calm <= 1'b1;
            else
                calm <= ($urandom_range(3, 0) == 0);

            nframes = $urandom_range(8, 4);
            for (int f = 0; f < nframes; f++)
                send_frame($urandom_range(8, 1), $urandom_range(6, 1),
                           $urandom_range(7, 0) == 0, $urandom_range(3, 0) == 0,
                           $urandom_range(5, 0) == 0);
            settle();
            phase++;
        end

        $display("covered %0d pixels in %0d frames under %0d register settings",
                 pixels_sent, frames_sent, settings_used + 1);
        $display("checked %0d crop results, %0d mismatches", crop_checked, mismatch_count);
        if (mismatch_count == 0 && crop_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
